// ===== rtl/pws_pkg.sv =====
// Shared widths, defaults and saturation bounds for the weight-matrix window scorer.
`default_nettype none

package pws_pkg;

    localparam int MAX_WIDTH_DEF     = 32;
    localparam int ALPHABET_SIZE_DEF = 32;
    localparam int MAX_SEQ_LEN_DEF   = 65536;

    localparam int LETTER_W = 5;
    localparam int COLUMN_W = 5;
    localparam int WEIGHT_W = 24;
    localparam int CFG_W    = 6;
    localparam int SCORE_W  = 29;
    localparam int SITE_W   = 16;
    localparam int ACC_W    = 32;

    localparam logic signed [ACC_W-1:0] SCORE_MAX = 32'sd268435455;
    localparam logic signed [ACC_W-1:0] SCORE_MIN = -32'sd268435456;

    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_RESIDUE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/pwm_window_scorer.sv =====
// Top level of the weight-matrix window scorer: weight memory, letter history and scan sequencer.
`default_nettype none

// Weight-matrix window scorer. Load items (tuser action = 0) write one signed
// 24-bit log weight into an on-chip weight memory of MAX_WIDTH * ALPHABET_SIZE
// entries, addressed by column * ALPHABET_SIZE + letter. Residue items
// (action = 1) shift their letter into the letter history and advance the
// per-sequence position counter, which restarts on new_sequence and
// saturates at MAX_SEQ_LEN - 1. Once the current sequence holds at least
// motif_width letters, the block walks the window through the single read
// port of the weight memory, one column per cycle, and emits the saturated
// 29-bit sum together with the window's start offset. A scoring residue item
// occupies the block from the accepting cycle through one memory read per
// column, a drain step for the read latency, and a finish step that hands the
// sum to the output register; that last step waits as long as the previous
// result still sits unaccepted in the output register. A load item, or a
// residue item that gives no result, leaves the block idle and ready for the
// next item. Weights must be loaded before they are used: an entry that was
// never written reads as an unknown value. Letters at or above ALPHABET_SIZE
// score zero. The user must write motif_width through the cfg port only while
// the block is idle; the block itself does not enforce this. Zero acts as one
// and values above MAX_WIDTH act as MAX_WIDTH. The finished result sits in an
// output register, so the next item is accepted while it waits for m_tready.
module pwm_window_scorer #(
    parameter int MAX_WIDTH     = pws_pkg::MAX_WIDTH_DEF,
    parameter int ALPHABET_SIZE = pws_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_SEQ_LEN   = pws_pkg::MAX_SEQ_LEN_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    // Configuration write channel: motif_width.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [pws_pkg::CFG_W-1:0] cfg_data,

    // Input items.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata: residue [4:0], column [9:5], weight_value [33:10], zero fill [39:34].
    input  wire logic [39:0]               s_tdata,
    // s_tuser: action [0], new_sequence [1].
    input  wire logic [1:0]                s_tuser,

    // Result items.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata: score [28:0], site_start [44:29], zero fill [47:45].
    output logic [47:0]                    m_tdata
);

    localparam int DEPTH = MAX_WIDTH * ALPHABET_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int POS_W = $clog2(MAX_SEQ_LEN);
    localparam int CMP_W = POS_W + WW;
    localparam int LW    = pws_pkg::LETTER_W;
    localparam int WTW   = pws_pkg::WEIGHT_W;
    localparam int AC_W  = pws_pkg::ACC_W;

    // Unpacked input fields.
    logic                 in_action;
    logic                 in_new_seq;
    logic [LW-1:0]        in_residue;
    logic [pws_pkg::COLUMN_W-1:0] in_column;
    logic [WTW-1:0]       in_weight;

    assign in_residue = s_tdata[4:0];
    assign in_column  = s_tdata[9:5];
    assign in_weight  = s_tdata[33:10];
    assign in_action  = s_tuser[0];
    assign in_new_seq = s_tuser[1];

    // Control and payload registers.
    pws_pkg::state_t              state_reg, state_next;
    logic [pws_pkg::CFG_W-1:0]    cfg_width_reg;
    logic [LW-1:0]                hist_reg [MAX_WIDTH];
    logic [LW-1:0]                hist_next [MAX_WIDTH];
    logic [LW-1:0]                work_reg [MAX_WIDTH];
    logic [POS_W-1:0]             pos_reg;
    logic [POS_W-1:0]             site_reg;
    logic [CW-1:0]                col_reg;
    logic                         rd_vld_reg;
    logic                         rd_skip_reg;
    logic [WTW-1:0]               rd_data_reg;
    logic signed [AC_W-1:0]       acc_reg;
    logic                         m_valid_reg;
    logic [pws_pkg::SCORE_W-1:0]  m_score_reg;
    logic [POS_W-1:0]             m_site_reg;

    // Weight memory: written by load items, read one column per cycle during a scan.
    logic [WTW-1:0]               weight_mem [DEPTH];

    logic                         in_fire;
    logic                         load_fire;
    logic                         res_fire;
    logic                         load_in_range;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;
    logic                         scan_letter_ok;
    logic [WW-1:0]                w_eff;
    logic [POS_W-1:0]             pos_base;
    logic [POS_W-1:0]             pos_upd;
    logic                         window_full;
    logic                         out_load;
    logic signed [AC_W-1:0]       acc_clamped;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == pws_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (in_action == pws_pkg::ACTION_LOAD);
    assign res_fire  = in_fire && (in_action == pws_pkg::ACTION_RESIDUE);

    // A load outside the table's column or letter range is dropped.
    assign load_in_range = (7'(in_column) < 7'(MAX_WIDTH)) &&
                           (7'(in_residue) < 7'(ALPHABET_SIZE));
    assign wr_addr = AW'(in_column) * AW'(ALPHABET_SIZE) + AW'(in_residue);

    // The newest letter not yet scored sits at the bottom of the work copy;
    // it pairs with the column counting down from width - 1.
    assign scan_letter_ok = (7'(work_reg[0]) < 7'(ALPHABET_SIZE));
    assign rd_addr = AW'(col_reg) * AW'(ALPHABET_SIZE) + AW'(work_reg[0]);
    assign rd_en   = (state_reg == pws_pkg::ST_SCAN);

    // Effective window width.
    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (7'(cfg_width_reg) > 7'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(cfg_width_reg);
        end
    end

    // Position counter update for a residue item, saturating at its top.
    assign pos_base    = in_new_seq ? '0 : pos_reg;
    assign pos_upd     = (pos_base < POS_W'(MAX_SEQ_LEN - 1)) ? pos_base + 1'b1 : pos_base;
    assign window_full = (CMP_W'(pos_upd) >= CMP_W'(w_eff));

    // History after shifting in the incoming letter.
    always_comb begin
        hist_next[0] = in_residue;
        for (int i = 1; i < MAX_WIDTH; i++) begin
            hist_next[i] = hist_reg[i-1];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pws_pkg::ST_IDLE: begin
                if (res_fire && window_full) begin
                    state_next = pws_pkg::ST_SCAN;
                end
            end
            pws_pkg::ST_SCAN: begin
                if (col_reg == '0) begin
                    state_next = pws_pkg::ST_DRAIN;
                end
            end
            pws_pkg::ST_DRAIN: begin
                state_next = pws_pkg::ST_FINISH;
            end
            pws_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = pws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pws_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == pws_pkg::ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb begin
        if (acc_reg > pws_pkg::SCORE_MAX) begin
            acc_clamped = pws_pkg::SCORE_MAX;
        end else if (acc_reg < pws_pkg::SCORE_MIN) begin
            acc_clamped = pws_pkg::SCORE_MIN;
        end else begin
            acc_clamped = acc_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pws_pkg::ST_IDLE;
            cfg_width_reg <= pws_pkg::CFG_W'(1);
            pos_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (cfg_valid && cfg_ready) begin
                cfg_width_reg <= cfg_data;
            end
            if (res_fire) begin
                pos_reg <= pos_upd;
                for (int i = 0; i < MAX_WIDTH; i++) begin
                    hist_reg[i] <= hist_next[i];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Scan datapath and output payload.
    always_ff @(posedge aclk) begin
        if (res_fire) begin
            site_reg <= POS_W'(CMP_W'(pos_upd) - CMP_W'(w_eff));
            col_reg  <= CW'(w_eff - 1'b1);
            acc_reg  <= '0;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                work_reg[i] <= hist_next[i];
            end
        end else begin
            if (rd_en) begin
                col_reg <= col_reg - 1'b1;
                for (int i = 0; i < MAX_WIDTH - 1; i++) begin
                    work_reg[i] <= work_reg[i+1];
                end
            end
            if (rd_vld_reg && !rd_skip_reg) begin
                acc_reg <= acc_reg + {{(AC_W-WTW){rd_data_reg[WTW-1]}}, rd_data_reg};
            end
        end
        rd_skip_reg <= !scan_letter_ok;
        if (out_load) begin
            m_score_reg <= acc_clamped[pws_pkg::SCORE_W-1:0];
            m_site_reg  <= site_reg;
        end
    end

    // Weight memory ports. Loads are taken only while idle and reads only
    // during a scan, so the two never touch the memory in the same cycle.
    always_ff @(posedge aclk) begin
        if (load_fire && load_in_range) begin
            weight_mem[wr_addr] <= in_weight;
        end
        if (rd_en) begin
            rd_data_reg <= weight_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, pws_pkg::SITE_W'(m_site_reg), m_score_reg};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the weight-matrix window scorer, with its own score predictor.
`timescale 1ns / 100ps

module testbench;

    // Cycles without any accepted item before the run is declared hung. The
    // longest quiet stretch of a correct run is the receiver's long hold-off
    // plus a settle pause, a sender gap and one window scan.
    localparam int IDLE_LIMIT  = 3000;
    // Cycles allowed for the block to finish its last window before a
    // register write or the end of the run (the widest window plus margin).
    localparam int SETTLE_CYC  = 40;
    localparam int HOLD_CYC    = 400;
    localparam int SEQ_LIMIT   = pws_pkg::MAX_SEQ_LEN_DEF - 1;
    localparam int TABLE_DEPTH = pws_pkg::MAX_WIDTH_DEF * pws_pkg::ALPHABET_SIZE_DEF;
    // Residues only use letters 0 to 7 and the top letter, so only those
    // table entries need to be loaded before scoring starts.
    localparam int LOW_LETTERS = 8;
    localparam int TOP_LETTER  = 31;

    localparam logic [pws_pkg::WEIGHT_W-1:0] W_MAX = 24'h7FFFFF;
    localparam logic [pws_pkg::WEIGHT_W-1:0] W_MIN = 24'h800000;

    // One line of stimulus: either a register write or one input item. Where
    // typed is set, the expected outcome is the one written in the line;
    // otherwise the predictor supplies it.
    typedef struct packed {
        logic                         to_cfg;
        logic [pws_pkg::CFG_W-1:0]    cfg_val;
        logic                         act;
        logic                         nseq;
        logic [pws_pkg::LETTER_W-1:0] letter;
        logic [pws_pkg::COLUMN_W-1:0] col;
        logic [pws_pkg::WEIGHT_W-1:0] wt;
        logic                         typed;
        logic                         yields;
        logic [pws_pkg::SCORE_W-1:0]  score;
        logic [pws_pkg::SITE_W-1:0]   site;
    } row_t;

    typedef struct packed {
        logic [pws_pkg::SCORE_W-1:0] score;
        logic [pws_pkg::SITE_W-1:0]  site;
    } score_rec_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [pws_pkg::CFG_W-1:0]  cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    // s_tdata: residue [4:0], column [9:5], weight_value [33:10], zero fill [39:34].
    logic [39:0]                s_tdata;
    // s_tuser: action [0], new_sequence [1].
    logic [1:0]                 s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    // m_tdata: score [28:0], site_start [44:29], zero fill [47:45].
    logic [47:0]                m_tdata;

    pwm_window_scorer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor state: a private copy of the weight memory, the letter
    // history (entry 0 is the newest letter), the position counter and the
    // motif width register.
    logic signed [pws_pkg::WEIGHT_W-1:0] weight_copy [0:TABLE_DEPTH-1];
    logic [pws_pkg::LETTER_W-1:0]        letters_seen [0:pws_pkg::MAX_WIDTH_DEF-1];
    int                                  pos_count;
    logic [pws_pkg::CFG_W-1:0]           cur_width;

    // Scores that the block still owes, oldest first.
    score_rec_t pending_scores [$];

    int errors;
    int burst_left;
    int gap_max;

    // Receiver state: its own ready pattern and the one long hold-off.
    int         rx_mode;
    int         rx_left;
    bit         hold_arm;
    bit         hold_done;
    int         hold_wait;
    int         hold_left;
    score_rec_t rx_want;
    int         idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Applies one accepted item to the predictor. A load writes the private
    // weight copy; a residue shifts the history, steps the position counter
    // and, once the window is full, sums one weight per column with column 0
    // taking the oldest letter of the window.
    task automatic score_window(input row_t r, output bit hit, output score_rec_t res);
        int     ew;
        int     k;
        longint acc;
        hit = 1'b0;
        res = '0;
        if (r.act == pws_pkg::ACTION_LOAD) begin
            weight_copy[int'(r.col) * pws_pkg::ALPHABET_SIZE_DEF + int'(r.letter)] = r.wt;
        end else begin
            if (r.nseq) begin
                pos_count = 0;
            end
            for (k = pws_pkg::MAX_WIDTH_DEF - 1; k > 0; k--) begin
                letters_seen[k] = letters_seen[k-1];
            end
            letters_seen[0] = r.letter;
            if (pos_count < SEQ_LIMIT) begin
                pos_count++;
            end
            // Width zero behaves as one, anything past the maximum as the maximum.
            if (cur_width == 0) begin
                ew = 1;
            end else if (cur_width > pws_pkg::MAX_WIDTH_DEF) begin
                ew = pws_pkg::MAX_WIDTH_DEF;
            end else begin
                ew = cur_width;
            end
            if (pos_count >= ew) begin
                acc = 0;
                for (k = 0; k < ew; k++) begin
                    acc += weight_copy[k * pws_pkg::ALPHABET_SIZE_DEF +
                                       int'(letters_seen[ew-1-k])];
                end
                if (acc > pws_pkg::SCORE_MAX) begin
                    acc = pws_pkg::SCORE_MAX;
                end
                if (acc < pws_pkg::SCORE_MIN) begin
                    acc = pws_pkg::SCORE_MIN;
                end
                res.score = acc[pws_pkg::SCORE_W-1:0];
                res.site  = pws_pkg::SITE_W'(pos_count - ew);
                hit = 1'b1;
            end
        end
    endtask

    function automatic row_t load_row(input logic [4:0] col, input logic [4:0] letter,
                                      input logic [23:0] wt, input logic nseq);
        row_t r;
        r        = '0;
        r.act    = pws_pkg::ACTION_LOAD;
        r.nseq   = nseq;
        r.letter = letter;
        r.col    = col;
        r.wt     = wt;
        return r;
    endfunction

    function automatic row_t res_row(input logic nseq, input logic [4:0] letter);
        row_t r;
        r        = '0;
        r.act    = pws_pkg::ACTION_RESIDUE;
        r.nseq   = nseq;
        r.letter = letter;
        return r;
    endfunction

    function automatic row_t res_exp(input logic nseq, input logic [4:0] letter,
                                     input logic yields, input int score, input int site);
        row_t r;
        r        = res_row(nseq, letter);
        r.typed  = 1'b1;
        r.yields = yields;
        r.score  = score[pws_pkg::SCORE_W-1:0];
        r.site   = site[pws_pkg::SITE_W-1:0];
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [pws_pkg::CFG_W-1:0] v);
        row_t r;
        r         = '0;
        r.to_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    // Draws a letter from the loaded set: mostly 0 to 7, sometimes the top letter.
    function automatic logic [4:0] pick_letter();
        int lt;
        lt = $urandom_range(0, LOW_LETTERS);
        if (lt == LOW_LETTERS) begin
            lt = TOP_LETTER;
        end
        return 5'(lt);
    endfunction

    // Offers one item and returns at the edge where it was accepted. The
    // sender runs in bursts; a gap is only inserted at the start of a new
    // burst, so inside a burst tvalid stays high from item to item.
    task automatic send_item(input row_t r);
        int         gap;
        bit         hit;
        score_rec_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.wt, r.col, r.letter};
        s_tuser  <= {r.nseq, r.act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        score_window(r, hit, res);
        if (r.typed) begin
            if (r.yields) begin
                pending_scores.push_back({r.score, r.site});
            end
        end else if (hit) begin
            pending_scores.push_back(res);
        end
    endtask

    // Register writes happen only with the block idle: every owed score has
    // arrived and the last item, which may have produced nothing, has had
    // time to finish.
    task automatic settle_then_write(input logic [pws_pkg::CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cur_width = v;
    endtask

    // Result side: checks every accepted result against the oldest owed
    // score and drives m_tready from a randomly redrawn pattern, with one long
    // hold-off once the random part has begun.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_scores.size() == 0) begin
                    $display("%0t: expected no result, actual score %0d site %0d", $time,
                             $signed(m_tdata[28:0]), m_tdata[44:29]);
                    errors++;
                end else begin
                    rx_want = pending_scores.pop_front();
                    if (m_tdata[28:0] !== rx_want.score) begin
                        $display("%0t: score expected %0d, actual %0d", $time,
                                 $signed(rx_want.score), $signed(m_tdata[28:0]));
                        errors++;
                    end
                    if (m_tdata[44:29] !== rx_want.site) begin
                        $display("%0t: site_start expected %0d, actual %0d", $time,
                                 rx_want.site, m_tdata[44:29]);
                        errors++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(16, 96);
            end else begin
                rx_left--;
            end
            if (hold_arm && !hold_done) begin
                if (hold_wait == 0) begin
                    hold_left = HOLD_CYC;
                    hold_done = 1'b1;
                end else begin
                    hold_wait--;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // Watchdog: ends the run when nothing at all is accepted for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL pwm_window_scorer");
                $finish;
            end
        end
    end

    initial begin : stimulus
        row_t plan [$];
        row_t r;
        int   width_plan [10];
        int   p;
        int   n;
        int   k;
        int   ew;
        logic nseq;

        errors      = 0;
        burst_left  = 0;
        gap_max     = 12;
        rx_mode     = 0;
        rx_left     = 0;
        hold_arm    = 1'b0;
        hold_done   = 1'b0;
        hold_wait   = 60;
        hold_left   = 0;
        idle_cycles = 0;
        pos_count   = 0;
        cur_width   = 1;
        for (k = 0; k < pws_pkg::MAX_WIDTH_DEF; k++) begin
            letters_seen[k] = '0;
        end
        for (k = 0; k < TABLE_DEPTH; k++) begin
            weight_copy[k] = '0;
        end

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The weight memory is undefined until written, so every entry that a
        // residue can reach (letters 0 to 7 and the top letter, in every
        // column) gets a random weight before any residue is sent.
        for (k = 0; k < pws_pkg::MAX_WIDTH_DEF; k++) begin
            for (n = 0; n <= LOW_LETTERS; n++) begin
                send_item(load_row(5'(k), (n == LOW_LETTERS) ? 5'(TOP_LETTER) : 5'(n),
                                   24'($urandom), 1'($urandom_range(0, 1))));
            end
        end

        // Directed part: reset width, weight extremes, a load carrying
        // new_sequence (ignored), width zero and width past the maximum,
        // the short prefix, and a width change in the middle of a sequence.
        plan.push_back(load_row(5'd0, 5'd0, W_MAX, 1'b0));
        plan.push_back(res_exp(1'b1, 5'd0, 1'b1, 8388607, 0));
        plan.push_back(load_row(5'd0, 5'd31, W_MIN, 1'b1));
        plan.push_back(res_exp(1'b0, 5'd31, 1'b1, -8388608, 1));
        plan.push_back(cfg_row(6'd0));
        plan.push_back(res_exp(1'b1, 5'd31, 1'b1, -8388608, 0));
        plan.push_back(res_exp(1'b0, 5'd0, 1'b1, 8388607, 1));
        plan.push_back(cfg_row(6'd2));
        plan.push_back(load_row(5'd1, 5'd5, 24'd100, 1'b0));
        plan.push_back(res_exp(1'b1, 5'd0, 1'b0, 0, 0));
        plan.push_back(res_exp(1'b0, 5'd5, 1'b1, 8388707, 0));
        plan.push_back(load_row(5'd31, 5'd31, 24'd0, 1'b0));
        plan.push_back(res_row(1'b0, 5'd31));
        plan.push_back(cfg_row(6'd3));
        plan.push_back(res_row(1'b0, 5'd7));
        plan.push_back(cfg_row(6'd63));
        plan.push_back(res_exp(1'b0, 5'd1, 1'b0, 0, 0));
        plan.push_back(cfg_row(6'd32));
        plan.push_back(res_exp(1'b1, 5'd0, 1'b0, 0, 0));
        plan.push_back(load_row(5'd0, 5'd0, 24'd0, 1'b0));
        plan.push_back(cfg_row(6'd1));
        plan.push_back(res_exp(1'b0, 5'd0, 1'b1, 0, 1));
        plan.push_back(res_exp(1'b1, 5'd0, 1'b1, 0, 0));
        foreach (plan[i]) begin
            if (plan[i].to_cfg) begin
                settle_then_write(plan[i].cfg_val);
            end else begin
                send_item(plan[i]);
            end
        end

        // Full-width sums at both ends of the score range: every column
        // holds the largest weight for letter 1 and the smallest for letter 2.
        settle_then_write(6'd32);
        for (k = 0; k < pws_pkg::MAX_WIDTH_DEF; k++) begin
            send_item(load_row(5'(k), 5'd1, W_MAX, 1'b0));
            send_item(load_row(5'(k), 5'd2, W_MIN, 1'b0));
        end
        for (k = 0; k < 2 * pws_pkg::MAX_WIDTH_DEF; k++) begin
            send_item(res_row(k == 0, (k < pws_pkg::MAX_WIDTH_DEF) ? 5'd1 : 5'd2));
        end

        // Random part: a series of widths, each with a stream of residues
        // broken by occasional restarts and interleaved weight reloads. Wide
        // windows get few restarts so that results still come.
        hold_arm = 1'b1;
        width_plan = '{4, 1, 0, 32, 7, 2, 63, 13, 3, 33};
        for (p = 0; p < 10; p++) begin
            settle_then_write(6'(width_plan[p]));
            ew = (width_plan[p] == 0) ? 1 :
                 (width_plan[p] > pws_pkg::MAX_WIDTH_DEF) ? pws_pkg::MAX_WIDTH_DEF :
                 width_plan[p];
            for (n = 0; n < 42; n++) begin
                if ($urandom_range(0, 99) < 15) begin
                    r = load_row(5'($urandom), pick_letter(), 24'($urandom),
                                 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 9) == 0) begin
                        r.wt = $urandom_range(0, 1) ? W_MAX : W_MIN;
                    end
                end else begin
                    if (n == 0) begin
                        nseq = 1'($urandom_range(0, 1));
                    end else if (ew >= 16) begin
                        nseq = ($urandom_range(0, 199) == 0);
                    end else begin
                        nseq = ($urandom_range(0, 99) < 5);
                    end
                    r = res_row(nseq, pick_letter());
                end
                send_item(r);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS pwm_window_scorer");
        end else begin
            $display("FAIL pwm_window_scorer");
        end
        $finish;
    end

endmodule

// ===== pwm_window_scorer.f =====
rtl/pws_pkg.sv
rtl/pwm_window_scorer.sv
test/testbench.sv
